// ----- rtl/display_dirty_span_refresh_defines.svh -----
// assertion helpers for the dirty span refresh block
// the asserting module must have clk and rst_n in scope
`ifndef DISPLAY_DIRTY_SPAN_REFRESH_DEFINES_SVH
`define DISPLAY_DIRTY_SPAN_REFRESH_DEFINES_SVH

// same-cycle implication
`define DDSR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DDSR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ddsr_pkg.sv -----
`default_nettype none

package ddsr_pkg;

    // parameter defaults
    localparam int PANEL_WIDTH_DEF = 128;
    localparam int MAX_PAGES_DEF   = 8;
    localparam int CHUNK_BYTES_DEF = 15;

    // depth of the op queue and the result queue
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_PANEL_KIND   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAGES_IN_USE = 1'd1;

    localparam logic [1:0] PANEL_KIND_RESET = 2'd0;
    localparam logic [1:0] PANEL_OFFSET_TWO = 2'd2;
    localparam logic [3:0] PAGES_RESET      = 4'd8;

    // function codes
    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_PLOT    = 2'd1;
    localparam logic [1:0] FUNC_REFRESH = 2'd2;

    // pixel modes
    localparam logic [1:0] PIX_CLEAR  = 2'd0;
    localparam logic [1:0] PIX_SET    = 2'd1;
    localparam logic [1:0] PIX_TOGGLE = 2'd2;

    // message kinds and command format
    localparam logic       MSG_COMMAND = 1'b0;
    localparam logic       MSG_DATA    = 1'b1;
    localparam logic [3:0] CMD_LENGTH  = 4'd3;
    localparam logic [7:0] CMD_PAGE    = 8'hB0;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_CLEAR,
        OP_SET,
        OP_TOGGLE,
        OP_REFRESH
    } op_kind_t;

    typedef struct packed {
        logic [1:0] func;
        logic [9:0] byte_index;
        logic [7:0] byte_value;
        logic [6:0] pixel_x;
        logic [5:0] pixel_y;
        logic [1:0] pixel_mode;
        logic [3:0] page_index;
    } item_t;

    typedef struct packed {
        logic        msg_kind;
        logic [3:0]  msg_length;
        logic [63:0] payload_low;
        logic [55:0] payload_high;
        logic        last;
    } result_t;

    // classified work for the back end
    typedef struct packed {
        op_kind_t   kind;
        logic [9:0] index;
        logic [7:0] value;
        logic [3:0] page;
        logic [6:0] col;
        logic [2:0] bitn;
    } op_t;

endpackage

`default_nettype wire

// ----- rtl/ddsr_queue.sv -----
`default_nettype none

module ddsr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [IW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ddsr_front.sv -----
`default_nettype none

module ddsr_front #(
    parameter int PANEL_WIDTH = ddsr_pkg::PANEL_WIDTH_DEF,
    parameter int MAX_PAGES   = ddsr_pkg::MAX_PAGES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire ddsr_pkg::item_t                  item,
    input  wire logic                             cfg_write,
    input  wire logic [ddsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ddsr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             clearing,
    input  wire logic                             opq_full,
    output logic                                  opq_push,
    output ddsr_pkg::op_t                         opq_op,
    output logic [1:0]                            panel_kind
);

    localparam int STORE_BYTES = MAX_PAGES * PANEL_WIDTH;

    logic [1:0]    panel_kind_reg, panel_kind_next;
    logic [3:0]    pages_reg, pages_next;
    logic          keep;
    ddsr_pkg::op_t op;

    assign panel_kind = panel_kind_reg;

    always_comb
    begin
        panel_kind_next = panel_kind_reg;
        pages_next      = pages_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                ddsr_pkg::REG_PANEL_KIND:   panel_kind_next = cfg_data[1:0];
                ddsr_pkg::REG_PAGES_IN_USE: pages_next      = cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_kind_reg <= ddsr_pkg::PANEL_KIND_RESET;
            pages_reg      <= ddsr_pkg::PAGES_RESET;
        end
        else
        begin
            panel_kind_reg <= panel_kind_next;
            pages_reg      <= pages_next;
        end
    end

    // classify items and drop those with an unused code or out of range
    always_comb
    begin
        op       = '0;
        op.kind  = ddsr_pkg::OP_WRITE;
        op.index = item.byte_index;
        op.value = item.byte_value;
        op.col   = item.pixel_x;
        op.bitn  = item.pixel_y[2:0];
        op.page  = {1'b0, item.pixel_y[5:3]};
        keep     = 1'b0;
        case (item.func)
            ddsr_pkg::FUNC_WRITE:
            begin
                keep = (32'(item.byte_index) < STORE_BYTES);
            end
            ddsr_pkg::FUNC_PLOT:
            begin
                keep = (32'(item.pixel_x) < PANEL_WIDTH)
                       && (32'(item.pixel_y[5:3]) < MAX_PAGES);
                case (item.pixel_mode)
                    ddsr_pkg::PIX_CLEAR:  op.kind = ddsr_pkg::OP_CLEAR;
                    ddsr_pkg::PIX_SET:    op.kind = ddsr_pkg::OP_SET;
                    ddsr_pkg::PIX_TOGGLE: op.kind = ddsr_pkg::OP_TOGGLE;
                    default:              keep    = 1'b0;
                endcase
            end
            ddsr_pkg::FUNC_REFRESH:
            begin
                op.kind = ddsr_pkg::OP_REFRESH;
                op.page = item.page_index;
                keep    = (item.page_index < pages_reg)
                          && (32'(item.page_index) < MAX_PAGES);
            end
            default: keep = 1'b0;
        endcase
    end

    assign full     = opq_full || clearing;
    assign opq_push = push && !full && keep;
    assign opq_op   = op;

endmodule

`default_nettype wire

// ----- rtl/ddsr_back.sv -----
`default_nettype none

module ddsr_back #(
    parameter int PANEL_WIDTH = ddsr_pkg::PANEL_WIDTH_DEF,
    parameter int MAX_PAGES   = ddsr_pkg::MAX_PAGES_DEF,
    parameter int CHUNK_BYTES = ddsr_pkg::CHUNK_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       panel_kind,
    input  wire logic             opq_empty,
    input  wire ddsr_pkg::op_t    opq_op,
    output logic                  opq_pop,
    output logic                  clearing,
    input  wire logic             outq_full,
    output logic                  outq_push,
    output ddsr_pkg::result_t     outq_msg
);

    localparam int STORE_BYTES = MAX_PAGES * PANEL_WIDTH;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int CW          = $clog2(PANEL_WIDTH);
    localparam int NW          = CW + 1;
    localparam int KW          = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int LW          = $clog2(CHUNK_BYTES + 1);
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;
    localparam logic [8:0] COL_OFFSET   = 9'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLOT,
        ST_SCAN,
        ST_CMD,
        ST_FETCH,
        ST_EMIT
    } state_t;

    function automatic logic [AW-1:0] addr_of(input logic [3:0] page,
                                              input logic [CW-1:0] col);
        addr_of = AW'(32'(page) * PANEL_WIDTH + 32'(col));
    endfunction

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [NW-1:0]        cnt_reg, cnt_next;
    logic                 found_reg, found_next;
    logic [CW-1:0]        first_reg, first_next;
    logic [CW-1:0]        last_reg, last_next;
    logic [NW-1:0]        pos_reg, pos_next;
    logic [LW-1:0]        left_reg, left_next;
    logic [KW-1:0]        ki_reg, ki_next;
    logic                 dv_reg, dv_next;
    logic [CW-1:0]        dcol_reg, dcol_next;
    logic [KW-1:0]        dk_reg, dk_next;
    logic [3:0]           len_reg, len_next;
    logic [3:0]           page_reg, page_next;
    logic [AW-1:0]        plot_addr_reg, plot_addr_next;
    ddsr_pkg::op_kind_t   plot_kind_reg, plot_kind_next;
    logic [7:0]           plot_mask_reg, plot_mask_next;

    logic [7:0]           frame_mem [STORE_BYTES];
    logic [7:0]           shadow_mem [STORE_BYTES];
    logic [7:0]           frame_rd_reg, shadow_rd_reg;
    logic [7:0]           byte_reg [CHUNK_BYTES];

    logic                 frame_we, shadow_we, byte_we;
    logic [AW-1:0]        frame_wa, frame_ra, shadow_wa, shadow_ra;
    logic [7:0]           frame_wd, shadow_wd;

    logic [NW-1:0]        span_end;
    logic [NW-1:0]        span_left;
    logic [LW-1:0]        chunk_n;
    logic [CW-1:0]        scan_col;
    logic [8:0]           cmd_col;
    logic [119:0]         data_bytes;

    assign clearing  = (state_reg == ST_CLEAR);
    assign span_end  = NW'(last_reg) + 1'b1;
    assign span_left = span_end - pos_reg;
    assign chunk_n   = (32'(span_left) > CHUNK_BYTES) ? LW'(CHUNK_BYTES) : LW'(span_left);
    assign scan_col  = CW'(cnt_reg - 1'b1);
    assign cmd_col   = 9'(first_reg)
                       + ((panel_kind == ddsr_pkg::PANEL_OFFSET_TWO) ? COL_OFFSET : 9'd0);

    // gather chunk bytes, zero past the length
    always_comb
    begin
        data_bytes = '0;
        for (int j = 0; j < CHUNK_BYTES; j++)
        begin
            if (4'(j) < len_reg)
            begin
                data_bytes[8*j +: 8] = byte_reg[j];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        left_next      = left_reg;
        ki_next        = ki_reg;
        dv_next        = 1'b0;
        dcol_next      = dcol_reg;
        dk_next        = dk_reg;
        len_next       = len_reg;
        page_next      = page_reg;
        plot_addr_next = plot_addr_reg;
        plot_kind_next = plot_kind_reg;
        plot_mask_next = plot_mask_reg;
        opq_pop        = 1'b0;
        outq_push      = 1'b0;
        outq_msg       = '0;
        frame_we       = 1'b0;
        frame_wa       = '0;
        frame_wd       = '0;
        frame_ra       = '0;
        shadow_we      = 1'b0;
        shadow_wa      = '0;
        shadow_wd      = '0;
        shadow_ra      = '0;
        byte_we        = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                frame_we  = 1'b1;
                frame_wa  = clr_reg;
                shadow_we = 1'b1;
                shadow_wa = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!opq_empty)
                begin
                    opq_pop = 1'b1;
                    case (opq_op.kind)
                        ddsr_pkg::OP_WRITE:
                        begin
                            frame_we = 1'b1;
                            frame_wa = AW'(opq_op.index);
                            frame_wd = opq_op.value;
                        end
                        ddsr_pkg::OP_CLEAR, ddsr_pkg::OP_SET, ddsr_pkg::OP_TOGGLE:
                        begin
                            plot_addr_next = addr_of(opq_op.page, CW'(opq_op.col));
                            frame_ra       = plot_addr_next;
                            plot_kind_next = opq_op.kind;
                            plot_mask_next = 8'd1 << opq_op.bitn;
                            state_next     = ST_PLOT;
                        end
                        ddsr_pkg::OP_REFRESH:
                        begin
                            page_next  = opq_op.page;
                            cnt_next   = '0;
                            found_next = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PLOT:
            begin
                frame_we = 1'b1;
                frame_wa = plot_addr_reg;
                case (plot_kind_reg)
                    ddsr_pkg::OP_CLEAR:  frame_wd = frame_rd_reg & ~plot_mask_reg;
                    ddsr_pkg::OP_SET:    frame_wd = frame_rd_reg | plot_mask_reg;
                    ddsr_pkg::OP_TOGGLE: frame_wd = frame_rd_reg ^ plot_mask_reg;
                    default:             frame_wd = frame_rd_reg;
                endcase
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // read column cnt, compare column cnt-1
                if (32'(cnt_reg) < PANEL_WIDTH)
                begin
                    frame_ra  = addr_of(page_reg, cnt_reg[CW-1:0]);
                    shadow_ra = frame_ra;
                end
                if ((cnt_reg != '0) && (frame_rd_reg != shadow_rd_reg))
                begin
                    if (!found_reg)
                    begin
                        first_next = scan_col;
                    end
                    last_next  = scan_col;
                    found_next = 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == NW'(PANEL_WIDTH))
                begin
                    pos_next   = NW'(first_next);
                    state_next = found_next ? ST_CMD : ST_IDLE;
                end
            end
            ST_CMD:
            begin
                if (!outq_full)
                begin
                    outq_push               = 1'b1;
                    outq_msg.msg_kind       = ddsr_pkg::MSG_COMMAND;
                    outq_msg.msg_length     = ddsr_pkg::CMD_LENGTH;
                    outq_msg.payload_low    = {40'd0,
                                               CMD_COL_HIGH | 8'(cmd_col[8:4]),
                                               4'd0, cmd_col[3:0],
                                               ddsr_pkg::CMD_PAGE | {4'd0, page_reg}};
                    left_next               = chunk_n;
                    len_next                = 4'(chunk_n);
                    ki_next                 = '0;
                    state_next              = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (left_reg != '0)
                begin
                    frame_ra  = addr_of(page_reg, pos_reg[CW-1:0]);
                    dv_next   = 1'b1;
                    dcol_next = pos_reg[CW-1:0];
                    dk_next   = ki_reg;
                    pos_next  = pos_reg + 1'b1;
                    ki_next   = ki_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
                // byte arriving from the read issued last cycle
                if (dv_reg)
                begin
                    byte_we   = 1'b1;
                    shadow_we = 1'b1;
                    shadow_wa = addr_of(page_reg, dcol_reg);
                    shadow_wd = frame_rd_reg;
                end
            end
            ST_EMIT:
            begin
                if (!outq_full)
                begin
                    outq_push             = 1'b1;
                    outq_msg.msg_kind     = ddsr_pkg::MSG_DATA;
                    outq_msg.msg_length   = len_reg;
                    outq_msg.payload_low  = data_bytes[63:0];
                    outq_msg.payload_high = data_bytes[119:64];
                    outq_msg.last         = (pos_reg == span_end);
                    if (pos_reg == span_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        left_next  = chunk_n;
                        len_next   = 4'(chunk_n);
                        ki_next    = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            first_reg     <= '0;
            last_reg      <= '0;
            pos_reg       <= '0;
            left_reg      <= '0;
            ki_reg        <= '0;
            dv_reg        <= 1'b0;
            dcol_reg      <= '0;
            dk_reg        <= '0;
            len_reg       <= '0;
            page_reg      <= '0;
            plot_addr_reg <= '0;
            plot_kind_reg <= ddsr_pkg::OP_WRITE;
            plot_mask_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            pos_reg       <= pos_next;
            left_reg      <= left_next;
            ki_reg        <= ki_next;
            dv_reg        <= dv_next;
            dcol_reg      <= dcol_next;
            dk_reg        <= dk_next;
            len_reg       <= len_next;
            page_reg      <= page_next;
            plot_addr_reg <= plot_addr_next;
            plot_kind_reg <= plot_kind_next;
            plot_mask_reg <= plot_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_mem[frame_wa] <= frame_wd;
        end
        frame_rd_reg <= frame_mem[frame_ra];
    end

    always_ff @(posedge clk)
    begin
        if (shadow_we)
        begin
            shadow_mem[shadow_wa] <= shadow_wd;
        end
        shadow_rd_reg <= shadow_mem[shadow_ra];
    end

    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            byte_reg[dk_reg] <= frame_rd_reg;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/display_dirty_span_refresh.sv -----
// Page-organized monochrome frame store with a dirty-span refresh engine.
// Byte writes and pixel plots (clear, set, toggle) change the frame store;
// a refresh of one page compares it with a shadow copy of what the panel
// holds, and for a changed page sends one command message (page and column
// pointer, column plus two for panel kind two) and then data messages of at
// most CHUNK_BYTES bytes, copying each byte into the shadow copy as it goes.
// Unchanged or out-of-range pages and dropped writes give no result.
// After reset both stores are zeroed by a pass over all MAX_PAGES*PANEL_WIDTH
// bytes (1024 with the defaults) during which full stays high; configuration
// writes are taken at any time. An item is classified in the front end and
// queued; the back end works one op at a time through the frame and shadow
// memories, each with one read and one write port: a byte write is one
// write, a plot a read then a write, a refresh a scan over the page's
// columns, plus for a changed span a command and then a fetch and an emit
// for each chunk, with stalls while the result queue is full.
`default_nettype none

module display_dirty_span_refresh #(
    parameter int PANEL_WIDTH = ddsr_pkg::PANEL_WIDTH_DEF,
    parameter int MAX_PAGES   = ddsr_pkg::MAX_PAGES_DEF,
    parameter int CHUNK_BYTES = ddsr_pkg::CHUNK_BYTES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // item side
    input  wire logic                             push,
    output logic                                  full,
    input  wire ddsr_pkg::item_t                  item,
    // result side
    output logic                                  empty,
    input  wire logic                             pop,
    output ddsr_pkg::result_t                     result,
    // configuration writes
    input  wire logic                             cfg_write,
    input  wire logic [ddsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [ddsr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int OP_W  = $bits(ddsr_pkg::op_t);
    localparam int RES_W = $bits(ddsr_pkg::result_t);

    // front end to op queue
    logic              opq_push;
    ddsr_pkg::op_t     opq_wop;
    logic              opq_full;
    // op queue to back end
    logic [OP_W-1:0]   opq_rdata;
    logic              opq_empty;
    logic              opq_pop;
    // back end to result queue
    logic              outq_push;
    ddsr_pkg::result_t outq_msg;
    logic              outq_full;
    logic [RES_W-1:0]  outq_rdata;
    // shared status
    logic              clearing;
    logic [1:0]        panel_kind;

    // classify items, hold the configuration registers
    ddsr_front #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .MAX_PAGES   (MAX_PAGES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .clearing   (clearing),
        .opq_full   (opq_full),
        .opq_push   (opq_push),
        .opq_op     (opq_wop),
        .panel_kind (panel_kind)
    );

    // short op queue so item transfers go on while the back end is busy
    ddsr_queue #(
        .WIDTH (OP_W),
        .DEPTH (ddsr_pkg::QUEUE_DEPTH)
    ) u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (opq_push),
        .wdata (opq_wop),
        .full  (opq_full),
        .pop   (opq_pop),
        .rdata (opq_rdata),
        .empty (opq_empty)
    );

    // memories, scan and chunk engine
    ddsr_back #(
        .PANEL_WIDTH (PANEL_WIDTH),
        .MAX_PAGES   (MAX_PAGES),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .panel_kind (panel_kind),
        .opq_empty  (opq_empty),
        .opq_op     (ddsr_pkg::op_t'(opq_rdata)),
        .opq_pop    (opq_pop),
        .clearing   (clearing),
        .outq_full  (outq_full),
        .outq_push  (outq_push),
        .outq_msg   (outq_msg)
    );

    // result queue, its head is what the result ports show
    ddsr_queue #(
        .WIDTH (RES_W),
        .DEPTH (ddsr_pkg::QUEUE_DEPTH)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (outq_push),
        .wdata (outq_msg),
        .full  (outq_full),
        .pop   (pop),
        .rdata (outq_rdata),
        .empty (empty)
    );

    assign result = ddsr_pkg::result_t'(outq_rdata);

endmodule

`default_nettype wire

// ----- rtl/ddsr_checker.sv -----
`default_nettype none

`include "display_dirty_span_refresh_defines.svh"

module ddsr_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              empty,
    input wire logic              pop,
    input wire ddsr_pkg::result_t result
);

    // a waiting result holds until it is transferred
    `DDSR_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(result), "result changed while waiting")

    // command messages are three bytes, page opcode first, never the last one
    `DDSR_ASSERT_IMP(a_cmd_form, !empty && result.msg_kind == ddsr_pkg::MSG_COMMAND, result.msg_length == ddsr_pkg::CMD_LENGTH && !result.last && (result.payload_low[7:0] & 8'hF0) == ddsr_pkg::CMD_PAGE && result.payload_low[63:24] == 40'd0 && result.payload_high == 56'd0, "bad command message")

    // data messages carry at least one byte
    `DDSR_ASSERT_IMP(a_data_len, !empty && result.msg_kind == ddsr_pkg::MSG_DATA, result.msg_length != 4'd0, "empty data message")

    // a command is always followed by data of the same refresh
    `DDSR_ASSERT_NEXT(a_cmd_then_data, !empty && pop && result.msg_kind == ddsr_pkg::MSG_COMMAND, empty || result.msg_kind == ddsr_pkg::MSG_DATA, "command not followed by data")

endmodule

bind display_dirty_span_refresh ddsr_checker u_ddsr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire

// ----- verif/display_dirty_span_refresh_tb.sv -----
`default_nettype none

module display_dirty_span_refresh_tb;

    // codes the package leaves unnamed
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam logic [1:0] PIX_NONE     = 2'd3;
    localparam logic [7:0] CMD_COL_HIGH = 8'h10;

    localparam int STORE_BYTES     = ddsr_pkg::MAX_PAGES_DEF * ddsr_pkg::PANEL_WIDTH_DEF;
    localparam int GAP_MAX         = 12;
    localparam int CALM_RUN        = 30;
    // enough for two queued refreshes of an unchanged page plus the one at work
    localparam int SETTLE_CYCLES   = 450;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 52;
    localparam int PHASES          = 5;

    // one row of the directed table: typed_n < 0 means the predictor decides
    typedef struct {
        ddsr_pkg::item_t   it;
        int                typed_n;
        ddsr_pkg::result_t t0;
        ddsr_pkg::result_t t1;
    } step_t;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    ddsr_pkg::item_t   item;
    logic              empty;
    logic              pop;
    ddsr_pkg::result_t result;
    logic              cfg_write;
    logic [ddsr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ddsr_pkg::CFG_DATA_W-1:0]  cfg_data;

    // predictor state: frame store, what the panel holds, and the registers
    logic [7:0] frame_copy [0:STORE_BYTES-1];
    logic [7:0] panel_copy [0:STORE_BYTES-1];
    logic [1:0] kind_reg;
    logic [3:0] pages_reg;

    ddsr_pkg::result_t span_msgs [$];     // transfers caused by the latest item
    ddsr_pkg::result_t awaited_msgs [$];  // transfers not yet popped, oldest first
    step_t             plan [$];

    // register settings of the random phases, extremes included
    logic [3:0] phase_kind  [0:PHASES-1] = '{4'd2, 4'd1, 4'd3, 4'd0, 4'd2};
    logic [3:0] phase_pages [0:PHASES-1] = '{4'd8, 4'd4, 4'd1, 4'd15, 4'd2};

    int failures;
    int transfers_seen;
    int items_sent;
    int refreshes_sent;
    int cycle_count;
    int calm [0:1];
    int run_left [0:1];

    display_dirty_span_refresh dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void note_failure(string s);
        failures++;
        if (failures <= 10)
            $display("%s", s);
    endfunction

    function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
            note_failure($sformatf("transfer %0d %s: expected %h got %h",
                                   transfers_seen, name, want, got));
    endfunction

    // idle cycles for one side (0 sender, 1 receiver), with calm stretches of no idling
    function automatic int idle_cycles(int side);
        if (run_left[side] == 0)
        begin
            run_left[side] = CALM_RUN;
            calm[side] = ($urandom_range(0, 3) == 0);
        end
        run_left[side]--;
        return calm[side] ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // works out what one accepted item does to the stores and which transfers it causes
    function automatic void predict(ddsr_pkg::item_t it);
        int                addr;
        int                lim;
        int                base;
        int                first;
        int                lastp;
        int                col;
        int                pos;
        int                stop;
        int                n;
        logic [7:0]        mask;
        logic [7:0]        col_b;
        logic [119:0]      pl;
        ddsr_pkg::result_t m;

        span_msgs.delete();
        case (it.func)
            ddsr_pkg::FUNC_WRITE:
                frame_copy[it.byte_index] = it.byte_value;
            ddsr_pkg::FUNC_PLOT:
            begin
                // pixel column and row always land inside the store at these sizes
                addr = (it.pixel_y >> 3) * ddsr_pkg::PANEL_WIDTH_DEF + it.pixel_x;
                mask = 8'd1 << it.pixel_y[2:0];
                case (it.pixel_mode)
                    ddsr_pkg::PIX_CLEAR:  frame_copy[addr] = frame_copy[addr] & ~mask;
                    ddsr_pkg::PIX_SET:    frame_copy[addr] = frame_copy[addr] | mask;
                    ddsr_pkg::PIX_TOGGLE: frame_copy[addr] = frame_copy[addr] ^ mask;
                    default:    ;
                endcase
            end
            ddsr_pkg::FUNC_REFRESH:
            begin
                lim = (pages_reg > ddsr_pkg::MAX_PAGES_DEF) ? ddsr_pkg::MAX_PAGES_DEF
                                                            : pages_reg;
                if (it.page_index >= lim)
                    return;
                base  = it.page_index * ddsr_pkg::PANEL_WIDTH_DEF;
                first = -1;
                lastp = -1;
                for (int i = 0; i < ddsr_pkg::PANEL_WIDTH_DEF; i++)
                begin
                    if (frame_copy[base + i] != panel_copy[base + i])
                    begin
                        if (first < 0)
                            first = i;
                        lastp = i;
                    end
                end
                if (first < 0)
                    return;

                // command: page, column low nibble, column high nibble
                col   = first + ((kind_reg == ddsr_pkg::PANEL_OFFSET_TWO) ? 2 : 0);
                col_b = col[7:0];
                m = '0;
                m.msg_kind   = ddsr_pkg::MSG_COMMAND;
                m.msg_length = ddsr_pkg::CMD_LENGTH;
                m.payload_low[7:0]   = ddsr_pkg::CMD_PAGE | {4'd0, it.page_index};
                m.payload_low[15:8]  = {4'd0, col_b[3:0]};
                m.payload_low[23:16] = CMD_COL_HIGH | {4'd0, col_b[7:4]};
                span_msgs.push_back(m);

                // data chunks over the changed span, panel copy follows
                pos  = first;
                stop = lastp + 1;
                while (pos < stop)
                begin
                    n = stop - pos;
                    if (n > ddsr_pkg::CHUNK_BYTES_DEF)
                        n = ddsr_pkg::CHUNK_BYTES_DEF;
                    pl = '0;
                    for (int k = 0; k < n; k++)
                    begin
                        pl[8*k +: 8] = frame_copy[base + pos + k];
                        panel_copy[base + pos + k] = frame_copy[base + pos + k];
                    end
                    m = '0;
                    m.msg_kind     = ddsr_pkg::MSG_DATA;
                    m.msg_length   = n[3:0];
                    m.payload_low  = pl[63:0];
                    m.payload_high = pl[119:64];
                    m.last         = (pos + n >= stop);
                    span_msgs.push_back(m);
                    pos += n;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic ddsr_pkg::item_t byte_write(int idx, int val);
        ddsr_pkg::item_t it;
        it = '0;
        it.func       = ddsr_pkg::FUNC_WRITE;
        it.byte_index = idx[9:0];
        it.byte_value = val[7:0];
        return it;
    endfunction

    function automatic ddsr_pkg::item_t pixel_plot(int x, int y, logic [1:0] mode);
        ddsr_pkg::item_t it;
        it = '0;
        it.func       = ddsr_pkg::FUNC_PLOT;
        it.pixel_x    = x[6:0];
        it.pixel_y    = y[5:0];
        it.pixel_mode = mode;
        return it;
    endfunction

    function automatic ddsr_pkg::item_t page_refresh(int page);
        ddsr_pkg::item_t it;
        it = '0;
        it.func       = ddsr_pkg::FUNC_REFRESH;
        it.page_index = page[3:0];
        return it;
    endfunction

    function automatic ddsr_pkg::result_t msg(logic kind, logic [3:0] len,
                                              logic [63:0] lo, logic fin);
        ddsr_pkg::result_t m;
        m = '0;
        m.msg_kind    = kind;
        m.msg_length  = len;
        m.payload_low = lo;
        m.last        = fin;
        return m;
    endfunction

    function automatic void add_row(ddsr_pkg::item_t it, int n,
                                    ddsr_pkg::result_t a, ddsr_pkg::result_t b);
        step_t s;
        s.it      = it;
        s.typed_n = n;
        s.t0      = a;
        s.t1      = b;
        plan.push_back(s);
    endfunction

    // random item, mostly aimed at pages in use so that refreshes find spans
    function automatic ddsr_pkg::item_t random_item();
        logic [63:0]     raw;
        ddsr_pkg::item_t it;
        int              r;
        int              lim;

        raw = {$urandom, $urandom};
        it  = raw[$bits(ddsr_pkg::item_t)-1:0];
        lim = (pages_reg > ddsr_pkg::MAX_PAGES_DEF) ? ddsr_pkg::MAX_PAGES_DEF : pages_reg;
        if (lim == 0)
            lim = 1;
        r = $urandom_range(0, 99);
        if (r < 5)
            it.func = FUNC_UNUSED;
        else if (r < 42)
        begin
            it.func = ddsr_pkg::FUNC_WRITE;
            if ($urandom_range(0, 4) != 0)
                it.byte_index = 10'($urandom_range(0, lim - 1) * ddsr_pkg::PANEL_WIDTH_DEF
                                    + $urandom_range(0, ddsr_pkg::PANEL_WIDTH_DEF - 1));
        end
        else if (r < 74)
        begin
            it.func = ddsr_pkg::FUNC_PLOT;
            if ($urandom_range(0, 4) != 0)
                it.pixel_y = 6'($urandom_range(0, lim * 8 - 1));
            it.pixel_mode = ($urandom_range(0, 9) == 0) ? PIX_NONE
                                                         : 2'($urandom_range(0, 2));
        end
        else
        begin
            it.func = ddsr_pkg::FUNC_REFRESH;
            it.page_index = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                         : 4'($urandom_range(0, lim - 1));
        end
        return it;
    endfunction

    // one input transfer; called and returns at a falling edge
    task automatic send_item(ddsr_pkg::item_t it, int typed_n,
                             ddsr_pkg::result_t t0, ddsr_pkg::result_t t1);
        int gap;
        gap = idle_cycles(0);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item = it;
        push = 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict(it);
        if (typed_n < 0)
        begin
            foreach (span_msgs[i])
                awaited_msgs.push_back(span_msgs[i]);
        end
        else
        begin
            if (typed_n > 0)
                awaited_msgs.push_back(t0);
            if (typed_n > 1)
                awaited_msgs.push_back(t1);
        end
        items_sent++;
        if (it.func == ddsr_pkg::FUNC_REFRESH)
            refreshes_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [ddsr_pkg::CFG_INDEX_W-1:0] idx,
                             logic [ddsr_pkg::CFG_DATA_W-1:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == ddsr_pkg::REG_PANEL_KIND)
            kind_reg = val[1:0];
        else
            pages_reg = val;
    endtask

    task automatic wait_drained();
        while (awaited_msgs.size() != 0)
            @(negedge clk);
    endtask

    // result side: random stalls, compare against the oldest expectation
    initial
    begin
        ddsr_pkg::result_t want;
        int                stall;

        pop = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = idle_cycles(1);
            if (stall > 0)
            begin
                pop = 1'b0;
                repeat (stall) @(negedge clk);
            end
            pop = 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            if (awaited_msgs.size() == 0)
                note_failure($sformatf("transfer %0d arrived with nothing awaited: %h",
                                       transfers_seen, result));
            else
            begin
                want = awaited_msgs.pop_front();
                cmp_field("msg_kind",     want.msg_kind,     result.msg_kind);
                cmp_field("msg_length",   want.msg_length,   result.msg_length);
                cmp_field("payload_low",  want.payload_low,  result.payload_low);
                cmp_field("payload_high", want.payload_high, result.payload_high);
                cmp_field("last",         want.last,         result.last);
            end
            transfers_seen++;
            @(negedge clk);
        end
    end

    // stimulus
    initial
    begin
        ddsr_pkg::result_t none;
        ddsr_pkg::item_t   it;
        int                count;

        none           = '0;
        failures       = 0;
        transfers_seen = 0;
        items_sent     = 0;
        refreshes_sent = 0;
        calm           = '{0, 0};
        run_left       = '{0, 0};
        rst_n     = 1'b0;
        push      = 1'b0;
        item      = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        for (int i = 0; i < STORE_BYTES; i++)
        begin
            frame_copy[i] = 8'd0;
            panel_copy[i] = 8'd0;
        end
        kind_reg  = ddsr_pkg::PANEL_KIND_RESET;
        pages_reg = ddsr_pkg::PAGES_RESET;

        // directed table, reset register values
        add_row(page_refresh(0), 0, none, none);               // nothing changed since reset
        add_row(byte_write(0, 8'hFF), -1, none, none);
        add_row(page_refresh(0), 2,
                msg(ddsr_pkg::MSG_COMMAND, ddsr_pkg::CMD_LENGTH, 64'h10_00_B0, 1'b0),
                msg(ddsr_pkg::MSG_DATA, 4'd1, 64'hFF, 1'b1));
        add_row(byte_write(STORE_BYTES - 1, 8'h01), -1, none, none);
        add_row(pixel_plot(127, 63, ddsr_pkg::PIX_SET), -1, none, none);  // bottom right
        add_row(pixel_plot(0, 0, ddsr_pkg::PIX_CLEAR), -1, none, none);
        add_row(pixel_plot(0, 7, ddsr_pkg::PIX_TOGGLE), -1, none, none);
        add_row(pixel_plot(5, 5, PIX_NONE), -1, none, none);    // mode three leaves it alone
        add_row(page_refresh(7), 2,
                msg(ddsr_pkg::MSG_COMMAND, ddsr_pkg::CMD_LENGTH, 64'h17_0F_B7, 1'b0),
                msg(ddsr_pkg::MSG_DATA, 4'd1, 64'h81, 1'b1));
        add_row(page_refresh(0), 2,
                msg(ddsr_pkg::MSG_COMMAND, ddsr_pkg::CMD_LENGTH, 64'h10_00_B0, 1'b0),
                msg(ddsr_pkg::MSG_DATA, 4'd1, 64'h7E, 1'b1));
        add_row('1, -1, none, none);                            // function three, all ones
        add_row(page_refresh(15), 0, none, none);               // beyond the store
        add_row(byte_write(128, 8'hA5), -1, none, none);
        add_row(byte_write(255, 8'h5A), -1, none, none);
        add_row(page_refresh(1), -1, none, none);               // whole page, most transfers
        add_row(page_refresh(1), 0, none, none);                // now clean
        add_row(byte_write(STORE_BYTES - 1, 8'h00), -1, none, none);
        add_row(byte_write(STORE_BYTES - 2, 8'hFF), -1, none, none);
        add_row(page_refresh(7), 2,
                msg(ddsr_pkg::MSG_COMMAND, ddsr_pkg::CMD_LENGTH, 64'h17_0E_B7, 1'b0),
                msg(ddsr_pkg::MSG_DATA, 4'd2, 64'h00_FF, 1'b1));
        add_row(pixel_plot(64, 40, ddsr_pkg::PIX_TOGGLE), -1, none, none);
        add_row(pixel_plot(64, 40, ddsr_pkg::PIX_TOGGLE), -1, none, none);
        add_row(page_refresh(5), 0, none, none);                // toggled back, no change
        add_row(byte_write(600, 8'h3C), -1, none, none);
        add_row(page_refresh(4), 2,
                msg(ddsr_pkg::MSG_COMMAND, ddsr_pkg::CMD_LENGTH, 64'h15_08_B4, 1'b0),
                msg(ddsr_pkg::MSG_DATA, 4'd1, 64'h3C, 1'b1));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // the block clears its stores first, full holds the sender off
        foreach (plan[i])
            send_item(plan[i].it, plan[i].typed_n, plan[i].t0, plan[i].t1);
        push = 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge clk);
            write_reg(ddsr_pkg::REG_PANEL_KIND, phase_kind[p]);
            write_reg(ddsr_pkg::REG_PAGES_IN_USE, phase_pages[p]);
            count = 0;
            while (count < ITEMS_PER_PHASE)
            begin
                // hold the sender off until the result side has caught up
                if (p == 0 && count == 20)
                begin
                    push = 1'b0;
                    wait_drained();
                end
                it = random_item();
                send_item(it, -1, none, none);
                if (it.func != FUNC_UNUSED)
                    count++;
            end
            push = 1'b0;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (awaited_msgs.size() != 0)
            note_failure($sformatf("%0d transfers never arrived", awaited_msgs.size()));

        $display("run covered %0d items (%0d refreshes) over %0d register settings",
                 items_sent, refreshes_sent, PHASES + 1);
        $display("%0d transfers compared, %0d mismatches", transfers_seen, failures);
        if (failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
